// ===== rtl/gws_pkg.sv =====
package gws_pkg;

  localparam int NODE_COUNT_DEF   = 4096;
  localparam int MAX_WORD_LEN_DEF = 16;
  localparam int SYMBOL_COUNT     = 27;
  localparam int SYM_W            = 5;

  localparam logic [SYM_W-1:0] DELIM_SYM = 5'd26;
  localparam logic [SYM_W-1:0] LAST_LETTER_SYM = 5'd25;

  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_LA   = 8'h61;
  localparam logic [7:0] CASE_GAP  = 8'd32;

  localparam logic [1:0] K_BUILD  = 2'd0;
  localparam logic [1:0] K_LOOKUP = 2'd1;
  localparam logic [1:0] K_CLEAR  = 2'd2;
  localparam logic [1:0] K_NONE   = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic       last_letter;
  } req_t;

  typedef struct packed {
    logic        found;
    logic        store_full;
    logic        word_too_long;
    logic [12:0] nodes_used;
  } rsp_t;

  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] sym;
  } letter_t;

  function automatic letter_t letter_symbol(input logic [7:0] code);
    logic [7:0] c;
    letter_t    r;
    c = code;
    r = '0;
    if (c >= CHAR_LA && c <= CHAR_LA + 8'(LAST_LETTER_SYM)) c = c - CASE_GAP;
    if (c >= CHAR_A && c <= CHAR_A + 8'(LAST_LETTER_SYM)) begin
      r.valid = 1'b1;
      r.sym   = SYM_W'(c - CHAR_A);
    end
    return r;
  endfunction

endpackage

// ===== rtl/gaddag_word_store.sv =====
// build letter that is not last: only buffered; clear: resets the counters, then the word out
// lookup letter: 1 or 2 store steps (child read, node read, check), none once the lookup failed
// last lookup letter: then a mark read and the word out
// last build letter: node steps of child read, node read and check, a mark per path, about n*(n+1) steps for n letters
// one item at a time; a result may wait in the output register while the next item is taken
// rst is synchronous; it empties the store at once, no clearing pass over the memories
module gaddag_word_store #(
  parameter int NODE_COUNT   = gws_pkg::NODE_COUNT_DEF,
  parameter int MAX_WORD_LEN = gws_pkg::MAX_WORD_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  gws_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output gws_pkg::rsp_t rsp
);
  import gws_pkg::*;

  localparam int NODE_W  = $clog2(NODE_COUNT);
  localparam int CNT_W   = $clog2(NODE_COUNT + 1);
  localparam int LEN_W   = $clog2(MAX_WORD_LEN + 1);
  localparam int IDX_W   = $clog2(MAX_WORD_LEN);
  localparam int CDEPTH  = NODE_COUNT * SYMBOL_COUNT;
  localparam int CADDR_W = $clog2(CDEPTH);
  localparam int INFO_W  = NODE_W + SYM_W + 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RD_CHILD = 4'd1;
  localparam logic [3:0] S_RD_NODE  = 4'd2;
  localparam logic [3:0] S_CHECK    = 4'd3;
  localparam logic [3:0] S_MARK     = 4'd4;
  localparam logic [3:0] S_LK_END   = 4'd5;
  localparam logic [3:0] S_LK_CHK   = 4'd6;
  localparam logic [3:0] S_PUSH     = 4'd7;

  localparam logic [1:0] P_REV   = 2'd0;
  localparam logic [1:0] P_DELIM = 2'd1;
  localparam logic [1:0] P_FWD   = 2'd2;
  localparam logic [1:0] P_LK    = 2'd3;

  logic [3:0]         state;
  logic [1:0]         phase;
  logic               lk;
  logic [NODE_W-1:0]  node;
  logic [SYM_W-1:0]   sym_cur;
  logic [SYM_W-1:0]   lk_sym;
  logic               lk_last;
  logic [CADDR_W-1:0] slot;
  logic [NODE_W-1:0]  child_q;
  logic [INFO_W-1:0]  info;
  logic [IDX_W-1:0]   k;
  logic [IDX_W-1:0]   i;
  logic [CNT_W-1:0]   next_free;
  logic [LEN_W-1:0]   buf_len;
  logic               overflow;
  logic [NODE_W-1:0]  lookup_node;
  logic [4:0]         lookup_pos;
  logic               lookup_failed;
  logic               res_found;
  logic               res_full;
  logic               res_long;
  logic [SYM_W-1:0]   word_buf [MAX_WORD_LEN];

  logic               child_we;
  logic [CADDR_W-1:0] child_waddr;
  logic [NODE_W-1:0]  child_wdata;
  logic [CADDR_W-1:0] child_raddr;
  logic [NODE_W-1:0]  child_rdata;
  logic               node_we;
  logic [NODE_W-1:0]  node_waddr;
  logic [INFO_W-1:0]  node_wdata;
  logic [NODE_W-1:0]  node_raddr;
  logic [INFO_W-1:0]  node_rdata;

  logic [SYM_W-1:0]   sym_sel;
  logic               hit;
  logic               full_now;
  logic               accept;
  letter_t            let_in;
  logic               overflow_next;
  logic [31:0]        nf_wide;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign let_in    = letter_symbol(req.char_code);
  assign full_now  = (next_free == CNT_W'(NODE_COUNT));
  assign nf_wide   = 32'(next_free);

  always_comb begin
    unique case (phase)
      P_DELIM: sym_sel = DELIM_SYM;
      P_LK:    sym_sel = lk_sym;
      default: sym_sel = word_buf[i];
    endcase
  end

  assign child_raddr = CADDR_W'(node) * CADDR_W'(SYMBOL_COUNT) + CADDR_W'(sym_sel);
  assign node_raddr  = (state == S_LK_END) ? lookup_node : child_rdata;

  always_comb begin
    child_we    = 1'b0;
    child_waddr = slot;
    child_wdata = next_free[NODE_W-1:0];
    node_we     = 1'b0;
    node_waddr  = next_free[NODE_W-1:0];
    node_wdata  = {node, sym_cur, 1'b0};
    if (state == S_CHECK && !hit && !lk && !full_now) begin
      child_we = 1'b1;
      node_we  = 1'b1;
    end else if (state == S_MARK) begin
      node_we    = 1'b1;
      node_waddr = node;
      node_wdata = {info[INFO_W-1:1], 1'b1};
    end
  end

  gws_ram #(.WIDTH(NODE_W), .DEPTH(CDEPTH)) u_child_mem (
    .clk   (clk),
    .we    (child_we),
    .waddr (child_waddr),
    .wdata (child_wdata),
    .raddr (child_raddr),
    .rdata (child_rdata)
  );

  gws_ram #(.WIDTH(INFO_W), .DEPTH(NODE_COUNT)) u_node_mem (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  gws_edge #(.NODE_W(NODE_W), .CNT_W(CNT_W)) u_edge (
    .child     (child_q),
    .info      (node_rdata),
    .node      (node),
    .sym       (sym_cur),
    .next_free (next_free),
    .hit       (hit)
  );

  always_comb begin
    overflow_next = overflow;
    if (let_in.valid && buf_len == LEN_W'(MAX_WORD_LEN)) overflow_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (accept && req.kind == K_BUILD && let_in.valid && buf_len < LEN_W'(MAX_WORD_LEN)) begin
      word_buf[buf_len[IDX_W-1:0]] <= let_in.sym;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      next_free     <= CNT_W'(1);
      buf_len       <= '0;
      overflow      <= 1'b0;
      lookup_node   <= '0;
      lookup_pos    <= '0;
      lookup_failed <= 1'b0;
      rsp_valid     <= 1'b0;
      phase         <= P_REV;
      lk            <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_PUSH) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_found <= 1'b0;
            res_full  <= 1'b0;
            res_long  <= 1'b0;
            unique case (req.kind)
              K_CLEAR: begin
                next_free     <= CNT_W'(1);
                buf_len       <= '0;
                overflow      <= 1'b0;
                lookup_node   <= '0;
                lookup_pos    <= '0;
                lookup_failed <= 1'b0;
                state         <= S_PUSH;
              end
              K_BUILD: begin
                if (req.last_letter &&
                    (overflow_next || (buf_len == '0 && !let_in.valid))) begin
                  res_long <= overflow_next;
                  buf_len  <= '0;
                  overflow <= 1'b0;
                  state    <= S_PUSH;
                end else begin
                  if (let_in.valid && buf_len < LEN_W'(MAX_WORD_LEN)) begin
                    buf_len <= buf_len + 1'b1;
                  end
                  overflow <= overflow_next;
                  if (req.last_letter) begin
                    lk    <= 1'b0;
                    k     <= '0;
                    i     <= '0;
                    phase <= P_REV;
                    node  <= '0;
                    state <= S_RD_CHILD;
                  end
                end
              end
              K_LOOKUP: begin
                lk_last <= req.last_letter;
                if (!let_in.valid) begin
                  lookup_failed <= 1'b1;
                  state         <= S_LK_END;
                end else if (lookup_failed) begin
                  state <= S_LK_END;
                end else begin
                  lk     <= 1'b1;
                  lk_sym <= let_in.sym;
                  phase  <= P_LK;
                  node   <= lookup_node;
                  state  <= S_RD_CHILD;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_RD_CHILD: begin
          sym_cur <= sym_sel;
          slot    <= child_raddr;
          state   <= S_RD_NODE;
        end
        S_RD_NODE: begin
          child_q <= child_rdata;
          state   <= S_CHECK;
        end
        S_CHECK: begin
          if (lk) begin
            if (!hit) begin
              lookup_failed <= 1'b1;
              state         <= S_LK_END;
            end else if (phase == P_LK && lookup_pos == '0) begin
              node  <= child_q;
              phase <= P_DELIM;
              state <= S_RD_CHILD;
            end else begin
              lookup_node <= child_q;
              state       <= S_LK_END;
            end
          end else if (!hit && full_now) begin
            res_full <= 1'b1;
            buf_len  <= '0;
            overflow <= 1'b0;
            state    <= S_PUSH;
          end else begin
            if (hit) begin
              node <= child_q;
              info <= node_rdata;
            end else begin
              node      <= next_free[NODE_W-1:0];
              info      <= node_wdata;
              next_free <= next_free + 1'b1;
            end
            case (phase)
              P_REV: begin
                state <= S_RD_CHILD;
                if (i == '0) phase <= P_DELIM;
                else i <= i - 1'b1;
              end
              P_DELIM: begin
                if (LEN_W'(k) + 1'b1 < buf_len) begin
                  i     <= k + 1'b1;
                  phase <= P_FWD;
                  state <= S_RD_CHILD;
                end else begin
                  state <= S_MARK;
                end
              end
              default: begin
                if (LEN_W'(i) + 1'b1 < buf_len) begin
                  i     <= i + 1'b1;
                  state <= S_RD_CHILD;
                end else begin
                  state <= S_MARK;
                end
              end
            endcase
          end
        end
        S_MARK: begin
          if (LEN_W'(k) + 1'b1 < buf_len) begin
            k     <= k + 1'b1;
            i     <= k + 1'b1;
            phase <= P_REV;
            node  <= '0;
            state <= S_RD_CHILD;
          end else begin
            buf_len  <= '0;
            overflow <= 1'b0;
            state    <= S_PUSH;
          end
        end
        S_LK_END: begin
          if (lookup_pos != 5'd31) lookup_pos <= lookup_pos + 1'b1;
          state <= lk_last ? S_LK_CHK : S_IDLE;
        end
        S_LK_CHK: begin
          res_found     <= !lookup_failed && lookup_node != '0 && node_rdata[0];
          lookup_node   <= '0;
          lookup_pos    <= '0;
          lookup_failed <= 1'b0;
          state         <= S_PUSH;
        end
        S_PUSH: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PUSH && (!rsp_valid || !rsp_stall)) begin
      rsp.found         <= res_found;
      rsp.store_full    <= res_full;
      rsp.word_too_long <= res_long;
      rsp.nodes_used    <= nf_wide[12:0];
    end
  end

endmodule

// ===== rtl/gws_ram.sv =====
module gws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH] = '{default: '0};

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/gws_edge.sv =====
module gws_edge #(
  parameter int NODE_W = 12,
  parameter int CNT_W  = 13
) (
  input  logic [NODE_W-1:0]               child,
  input  logic [NODE_W+gws_pkg::SYM_W:0]  info,
  input  logic [NODE_W-1:0]               node,
  input  logic [gws_pkg::SYM_W-1:0]       sym,
  input  logic [CNT_W-1:0]                next_free,
  output logic                            hit
);
  import gws_pkg::*;

  // a pointer counts only if its target was allocated under this very slot
  assign hit = (child != '0) && (CNT_W'(child) < next_free) &&
               (info[NODE_W+SYM_W:SYM_W+1] == node) && (info[SYM_W:1] == sym);

endmodule

// ===== rtl/gws_chk.sv =====
module gws_chk (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input gws_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input gws_pkg::rsp_t rsp
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("word out after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled word changed");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $countones({rsp.found, rsp.store_full, rsp.word_too_long}) <= 1)
    else $error("more than one result flag");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall && req_stall |=> !(rsp_valid && !rsp_stall && $past(req_stall) &&
      $changed(rsp)))
    else $error("word replaced without handshake");

endmodule

bind gaddag_word_store gws_chk u_gws_chk (.*);

// ===== sim/tb_gaddag_word_store.sv =====
module tb_gaddag_word_store;
  timeunit 1ns;
  timeprecision 1ps;
  import gws_pkg::*;

  localparam int NODES  = NODE_COUNT_DEF;
  localparam int MAXLEN = MAX_WORD_LEN_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  gaddag_word_store u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow store
  logic [11:0] kids [NODES*SYMBOL_COUNT];
  bit          marks [NODES];
  int          free_node;
  logic [4:0]  wbuf [MAXLEN];
  int          wlen;
  bit          woverflow;
  int          lk_node, lk_pos;
  bit          lk_failed;

  rsp_t expected_words[$];
  int   mismatches = 0;
  bit   hold_off = 1'b0;
  bit   stim_done = 1'b0;

  function automatic int sym_of(input logic [7:0] code);
    int c;
    c = code;
    if (c >= "a" && c <= "z") c -= 32;
    if (c >= "A" && c <= "Z") return c - "A";
    return 255;
  endfunction

  function automatic void wipe_store();
    foreach (kids[i]) kids[i] = '0;
    foreach (marks[i]) marks[i] = 1'b0;
    free_node = 1;
    wlen = 0;
    woverflow = 1'b0;
    lk_node = 0; lk_pos = 0; lk_failed = 1'b0;
  endfunction

  function automatic int grow(input int node, input int s);
    int slot, ch;
    slot = node * SYMBOL_COUNT + s;
    ch = kids[slot];
    if (ch != 0) return ch;
    if (free_node >= NODES) return -1;
    ch = free_node++;
    for (int j = 0; j < SYMBOL_COUNT; j++) kids[ch*SYMBOL_COUNT+j] = '0;
    marks[ch] = 1'b0;
    kids[slot] = 12'(ch);
    return ch;
  endfunction

  function automatic int walk(input int node, input int s);
    int ch;
    ch = kids[node * SYMBOL_COUNT + s];
    return (ch == 0) ? -1 : ch;
  endfunction

  function automatic bit insert_paths();
    int node;
    for (int k = 0; k < wlen; k++) begin
      node = 0;
      for (int i = k; i >= 0; i--) begin
        node = grow(node, wbuf[i]);
        if (node < 0) return 1'b1;
      end
      node = grow(node, DELIM_SYM);
      if (node < 0) return 1'b1;
      for (int i = k + 1; i < wlen; i++) begin
        node = grow(node, wbuf[i]);
        if (node < 0) return 1'b1;
      end
      marks[node] = 1'b1;
    end
    return 1'b0;
  endfunction

  // returns 1 and fills r when the word gives a result
  function automatic bit predict_store(input req_t w, output rsp_t r);
    int s, node;
    r = '0;
    s = sym_of(w.char_code);
    if (w.kind == K_NONE) return 1'b0;
    if (w.kind == K_CLEAR) begin
      wipe_store();
    end else if (w.kind == K_BUILD) begin
      if (s < 26) begin
        if (wlen < MAXLEN) wbuf[wlen++] = 5'(s);
        else woverflow = 1'b1;
      end
      if (!w.last_letter) return 1'b0;
      if (woverflow) r.word_too_long = 1'b1;
      else if (insert_paths()) r.store_full = 1'b1;
      wlen = 0;
      woverflow = 1'b0;
    end else begin
      if (s >= 26) lk_failed = 1'b1;
      else if (!lk_failed) begin
        node = walk(lk_node, s);
        if (node >= 0 && lk_pos == 0) node = walk(node, DELIM_SYM);
        if (node < 0) lk_failed = 1'b1;
        else lk_node = node;
      end
      if (lk_pos < 31) lk_pos++;
      if (!w.last_letter) return 1'b0;
      if (!lk_failed && lk_node != 0) r.found = marks[lk_node];
      lk_node = 0; lk_pos = 0; lk_failed = 1'b0;
    end
    r.nodes_used = 13'(free_node);
    return 1'b1;
  endfunction

  function automatic void note_mismatch(input rsp_t e, input rsp_t a);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch: expected found=%0d full=%0d long=%0d nodes=%0d, got %0d %0d %0d %0d",
               e.found, e.store_full, e.word_too_long, e.nodes_used,
               a.found, a.store_full, a.word_too_long, a.nodes_used);
  endfunction

  // sends one word; where has_fixed, the prediction is checked against a typed result
  task automatic send_word(input req_t w, input bit has_fixed, input rsp_t fixed);
    rsp_t r;
    int gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (predict_store(w, r)) begin
      if (has_fixed && r != fixed) note_mismatch(fixed, r);
      expected_words.push_back(r);
    end
    @(negedge clk);
  endtask

  task automatic send_text(input kind_sel, input string txt);
    req_t w;
    for (int i = 0; i < txt.len(); i++) begin
      w.kind = kind_sel ? K_LOOKUP : K_BUILD;
      w.char_code = txt[i];
      w.last_letter = (i == txt.len() - 1);
      send_word(w, 1'b0, '0);
    end
  endtask

  // receiver side
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_words.size() == 0) begin
        note_mismatch('0, rsp);
      end else if (rsp != expected_words[0]) begin
        note_mismatch(expected_words[0], rsp);
        void'(expected_words.pop_front());
      end else begin
        void'(expected_words.pop_front());
      end
    end
  end

  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_off) rsp_stall <= 1'b1;
      else if ($urandom_range(0, 3) == 0) begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
        rsp_stall <= 1'b1;
        repeat (n) @(negedge clk);
        rsp_stall <= 1'b0;
      end else rsp_stall <= 1'b0;
    end
  end

  typedef struct {
    req_t w;
    bit   has_fixed;
    rsp_t fixed;
  } row_t;

  localparam string POOL = "ABCDEFGHIJKLMNOPQRSTUVWXYZ";

  function automatic string random_word(input int len, input int alpha);
    string t;
    byte ch;
    t = "";
    for (int i = 0; i < len; i++) begin
      ch = POOL[$urandom_range(0, alpha - 1)];
      if ($urandom_range(0, 3) == 0) ch = ch + 8'd32;
      t = {t, string'(ch)};
    end
    return t;
  endfunction

  initial begin
    row_t rows[$];
    string words[$];
    string t;
    req_t w;
    int pick, len;
    wipe_store();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    rows.push_back('{'{K_LOOKUP, "A", 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 13'd1}});
    rows.push_back('{'{K_BUILD, 8'h00, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 13'd1}});
    rows.push_back('{'{K_NONE, "Q", 1'b1}, 1'b0, '0});
    rows.push_back('{'{K_BUILD, "z", 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 13'd3}});
    rows.push_back('{'{K_LOOKUP, "Z", 1'b1}, 1'b1, '{1'b1, 1'b0, 1'b0, 13'd3}});
    rows.push_back('{'{K_LOOKUP, 8'hFF, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 13'd3}});
    rows.push_back('{'{K_BUILD, "A", 1'b0}, 1'b0, '0});
    rows.push_back('{'{K_BUILD, "@", 1'b0}, 1'b0, '0});
    rows.push_back('{'{K_BUILD, "b", 1'b1}, 1'b0, '0});
    rows.push_back('{'{K_LOOKUP, "a", 1'b0}, 1'b0, '0});
    rows.push_back('{'{K_LOOKUP, "[", 1'b0}, 1'b0, '0});
    rows.push_back('{'{K_LOOKUP, "B", 1'b1}, 1'b0, '0});
    rows.push_back('{'{K_LOOKUP, "A", 1'b0}, 1'b0, '0});
    rows.push_back('{'{K_LOOKUP, "B", 1'b1}, 1'b0, '0});
    rows.push_back('{'{K_LOOKUP, "B", 1'b0}, 1'b0, '0});
    rows.push_back('{'{K_LOOKUP, "A", 1'b1}, 1'b0, '0});
    rows.push_back('{'{K_CLEAR, 8'h80, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0, 13'd1}});
    foreach (rows[i]) send_word(rows[i].w, rows[i].has_fixed, rows[i].fixed);

    // overlong word: 17 letters
    for (int i = 0; i < 17; i++) begin
      w = '{K_BUILD, 8'(CHAR_A + i), i == 16};
      send_word(w, i == 16, '{1'b0, 1'b0, 1'b1, 13'd1});
    end
    // exactly 16 letters, then look it up
    send_text(1'b0, "ABCDEFGHIJKLMNOP");
    send_text(1'b1, "ABCDEFGHIJKLMNOP");
    // long lookup past saturation
    for (int i = 0; i < 34; i++) begin
      w = '{K_LOOKUP, "A", i == 33};
      send_word(w, 1'b0, '0);
    end

    // receiver holds off while sender keeps going
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 30; i++) begin
        w = '{K_LOOKUP, 8'($urandom_range(0, 255)), 1'b1};
        send_word(w, 1'b0, '0);
      end
    join

    // random phase: mostly built words and lookups of them
    for (int it = 0; it < 300; it++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
        t = random_word(len, ($urandom_range(0, 1) == 0) ? 4 : 26);
        words.push_back(t);
        send_text(1'b0, t);
      end else if (pick < 75 && words.size() > 0) begin
        t = words[$urandom_range(0, words.size() - 1)];
        if ($urandom_range(0, 3) == 0) t = t.substr(0, $urandom_range(0, t.len() - 1));
        send_text(1'b1, t);
      end else if (pick < 90) begin
        send_text(1'b1, random_word($urandom_range(1, 5), 4));
      end else if (pick < 98) begin
        w.kind = 2'($urandom_range(0, 3));
        w.char_code = 8'($urandom_range(0, 255));
        w.last_letter = 1'($urandom_range(0, 1));
        send_word(w, 1'b0, '0);
      end else begin
        w = '{K_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))};
        send_word(w, 1'b0, '0);
        words.delete();
      end
    end

    // fill the store until it runs out
    for (int it = 0; it < 400 && free_node < NODES; it++)
      send_text(1'b0, random_word(16, 26));
    send_text(1'b0, random_word(16, 26));
    send_text(1'b1, "AB");
    w = '{K_CLEAR, 8'h00, 1'b1};
    send_word(w, 1'b1, '{1'b0, 1'b0, 1'b0, 13'd1});
    req_valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #30ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gws_pkg.sv
rtl/gws_ram.sv
rtl/gws_edge.sv
rtl/gaddag_word_store.sv
rtl/gws_chk.sv
sim/tb_gaddag_word_store.sv
